// ----- rtl/ttus_pkg.sv -----
package ttus_pkg;

   localparam int CHAR_W = 8;
   localparam int PART_W = 31;
   localparam int FRAC_W = 10;
   localparam int FDIG_W = 2;
   localparam int TIME_W = 63;
   localparam int K_W    = 10;
   localparam int STEP_W = 3;

   localparam logic [PART_W-1:0] PART_MAX = 31'h7FFF_FFFF;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;

   localparam logic [1:0] PART_COUNT_LAST = 2'd2;
   localparam logic [FDIG_W-1:0] FDIG_MAX = 2'd3;

   localparam logic [K_W-1:0] K_SIXTY = 10'd60;
   localparam logic [K_W-1:0] K_MILLE = 10'd1000;

   // conversion schedule: acc = acc * k + addend
   localparam logic [STEP_W-1:0] STEP_HOUR   = 3'd0;
   localparam logic [STEP_W-1:0] STEP_MINUTE = 3'd1;
   localparam logic [STEP_W-1:0] STEP_SECOND = 3'd2;
   localparam logic [STEP_W-1:0] STEP_FRAC   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_PAD    = 3'd4;
   localparam logic [STEP_W-1:0] STEP_MICRO  = 3'd5;

   typedef struct packed {
      logic              ok;
      logic [PART_W-1:0] hour;
      logic [PART_W-1:0] minute;
      logic [PART_W-1:0] second;
      logic [FRAC_W-1:0] frac;
      logic [FDIG_W-1:0] fdig;
   } snap_type;

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic [K_W-1:0] pow10(input logic [FDIG_W-1:0] d);
      logic [K_W-1:0] r;
      case (d)
         2'd0:    r = 10'd1;
         2'd1:    r = 10'd10;
         2'd2:    r = 10'd100;
         default: r = 10'd1000;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/ttus_req_if.sv -----
interface ttus_req_if import ttus_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              mode;
   logic [CHAR_W-1:0] char_code;

   modport source(output valid, output mode, output char_code, input ready);
   modport sink(input valid, input mode, input char_code, output ready);
endinterface

// ----- rtl/ttus_rsp_if.sv -----
interface ttus_rsp_if import ttus_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] time_us;
   logic              valid_res;

   modport source(output valid, output time_us, output valid_res, input ready);
   modport sink(input valid, input time_us, input valid_res, output ready);
endinterface

// ----- rtl/ttus_scan.sv -----
module ttus_scan import ttus_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              take_char,
   input  logic              take_end,
   input  logic [CHAR_W-1:0] char_code,
   output snap_type          snap
);

   logic [PART_W-1:0] part1_ff, part1_in;
   logic [PART_W-1:0] part2_ff, part2_in;
   logic [PART_W-1:0] part3_ff, part3_in;
   logic [1:0]        pcount_ff, pcount_in;
   logic              has_digit_ff, has_digit_in;
   logic              in_frac_ff, in_frac_in;
   logic [FRAC_W-1:0] fval_ff, fval_in;
   logic [FDIG_W-1:0] fdig_ff, fdig_in;
   logic              seen_ff, seen_in;
   logic              trail_ff, trail_in;
   logic              err_ff, err_in;

   logic [PART_W-1:0] cur_part;
   logic [PART_W+3:0] cur_next;
   logic [3:0]        digit;
   logic              is_digit;

   assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign digit    = 4'(char_code - CHAR_ZERO);

   always_comb begin
      case (pcount_ff)
         2'd0:    cur_part = part1_ff;
         2'd1:    cur_part = part2_ff;
         default: cur_part = part3_ff;
      endcase
   end

   // part * 10 + digit, wide enough to see overflow
   assign cur_next = {1'b0, cur_part, 3'b000} + {3'b000, cur_part, 1'b0} + (PART_W+4)'(digit);

   always_comb begin
      part1_in     = part1_ff;
      part2_in     = part2_ff;
      part3_in     = part3_ff;
      pcount_in    = pcount_ff;
      has_digit_in = has_digit_ff;
      in_frac_in   = in_frac_ff;
      fval_in      = fval_ff;
      fdig_in      = fdig_ff;
      seen_in      = seen_ff;
      trail_in     = trail_ff;
      err_in       = err_ff;
      if (take_end) begin
         part1_in     = '0;
         part2_in     = '0;
         part3_in     = '0;
         pcount_in    = '0;
         has_digit_in = 1'b0;
         in_frac_in   = 1'b0;
         fval_in      = '0;
         fdig_in      = '0;
         seen_in      = 1'b0;
         trail_in     = 1'b0;
         err_in       = 1'b0;
      end else if (take_char && !err_ff) begin
         if (is_space(char_code)) begin
            if (seen_ff) begin
               trail_in = 1'b1;
            end
         end else if (trail_ff) begin
            err_in = 1'b1;
         end else begin
            seen_in = 1'b1;
            if (is_digit) begin
               if (in_frac_ff) begin
                  if (fdig_ff < FDIG_MAX) begin
                     fval_in = {fval_ff[6:0], 3'b000} + {fval_ff[8:0], 1'b0}
                               + FRAC_W'(digit);
                     fdig_in = fdig_ff + 2'd1;
                  end
               end else if (cur_next > (PART_W+4)'(PART_MAX)) begin
                  err_in = 1'b1;
               end else begin
                  has_digit_in = 1'b1;
                  case (pcount_ff)
                     2'd0:    part1_in = cur_next[PART_W-1:0];
                     2'd1:    part2_in = cur_next[PART_W-1:0];
                     default: part3_in = cur_next[PART_W-1:0];
                  endcase
               end
            end else if (char_code == CHAR_COLON) begin
               if (in_frac_ff || !has_digit_ff || pcount_ff >= PART_COUNT_LAST) begin
                  err_in = 1'b1;
               end else begin
                  pcount_in    = pcount_ff + 2'd1;
                  has_digit_in = 1'b0;
               end
            end else if (char_code == CHAR_DOT || char_code == CHAR_COMMA) begin
               if (in_frac_ff || !has_digit_ff) begin
                  err_in = 1'b1;
               end else begin
                  in_frac_in = 1'b1;
               end
            end else begin
               err_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part1_ff     <= '0;
         part2_ff     <= '0;
         part3_ff     <= '0;
         pcount_ff    <= '0;
         has_digit_ff <= 1'b0;
         in_frac_ff   <= 1'b0;
         fval_ff      <= '0;
         fdig_ff      <= '0;
         seen_ff      <= 1'b0;
         trail_ff     <= 1'b0;
         err_ff       <= 1'b0;
      end else begin
         part1_ff     <= part1_in;
         part2_ff     <= part2_in;
         part3_ff     <= part3_in;
         pcount_ff    <= pcount_in;
         has_digit_ff <= has_digit_in;
         in_frac_ff   <= in_frac_in;
         fval_ff      <= fval_in;
         fdig_ff      <= fdig_in;
         seen_ff      <= seen_in;
         trail_ff     <= trail_in;
         err_ff       <= err_in;
      end
   end

   // snapshot of the text seen so far, taken on the end beat
   always_comb begin
      snap.ok   = !err_ff && seen_ff && (pcount_ff != 2'd0) && has_digit_ff;
      snap.frac = fval_ff;
      snap.fdig = fdig_ff;
      if (pcount_ff == PART_COUNT_LAST) begin
         snap.hour   = part1_ff;
         snap.minute = part2_ff;
         snap.second = part3_ff;
      end else begin
         snap.hour   = '0;
         snap.minute = part1_ff;
         snap.second = part2_ff;
      end
   end

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff && !take_end |=> err_ff)
      else $error("error flag dropped before end beat");

   a_part_count: assert property (@(posedge clock) disable iff (reset)
      pcount_ff != 2'd3)
      else $error("more than three parts tracked");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      fval_ff <= 10'd999)
      else $error("fraction above three digits");

endmodule

// ----- rtl/ttus_mac.sv -----
module ttus_mac import ttus_pkg::*; (
   input  logic [TIME_W-1:0] acc,
   input  logic [K_W-1:0]    k,
   input  logic [PART_W-1:0] addend,
   output logic [TIME_W-1:0] result
);

   logic [TIME_W+K_W-1:0] prod;

   assign prod   = (TIME_W+K_W)'(acc) * (TIME_W+K_W)'(k);
   assign result = prod[TIME_W-1:0] + TIME_W'(addend);

endmodule

// ----- rtl/ttus_conv.sv -----
module ttus_conv import ttus_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  snap_type          snap,
   input  logic              out_free,
   output logic              busy,
   output logic              done,
   output logic [TIME_W-1:0] time_us,
   output logic              valid_res
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   snap_type          snap_ff, snap_in;
   logic [TIME_W-1:0] acc_ff, acc_in;

   logic [K_W-1:0]    mac_k;
   logic [PART_W-1:0] mac_add;
   logic [TIME_W-1:0] mac_out;

   // operand schedule: Horner over h, m, s, then fraction, padding and the x1000 step
   always_comb begin
      case (step_ff)
         STEP_HOUR: begin
            mac_k   = K_SIXTY;
            mac_add = snap_ff.hour;
         end
         STEP_MINUTE: begin
            mac_k   = K_SIXTY;
            mac_add = snap_ff.minute;
         end
         STEP_SECOND: begin
            mac_k   = K_SIXTY;
            mac_add = snap_ff.second;
         end
         STEP_FRAC: begin
            mac_k   = pow10(snap_ff.fdig);
            mac_add = PART_W'(snap_ff.frac);
         end
         STEP_PAD: begin
            mac_k   = pow10(FDIG_MAX - snap_ff.fdig);
            mac_add = '0;
         end
         default: begin
            mac_k   = K_MILLE;
            mac_add = '0;
         end
      endcase
   end

   ttus_mac u_mac (
      .acc    (acc_ff),
      .k      (mac_k),
      .addend (mac_add),
      .result (mac_out)
   );

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      snap_in  = snap_ff;
      acc_in   = acc_ff;
      done     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               snap_in  = snap;
               acc_in   = '0;
               step_in  = STEP_HOUR;
               state_in = snap.ok ? ST_RUN : ST_HOLD;
            end
         end
         ST_RUN: begin
            acc_in  = mac_out;
            step_in = step_ff + 3'd1;
            if (step_ff == STEP_MICRO) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_HOUR;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      snap_ff <= snap_in;
      acc_ff  <= acc_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign time_us   = acc_ff;
   assign valid_res = snap_ff.ok;

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("converter state not one-hot");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> step_ff <= STEP_MICRO)
      else $error("step counter past schedule");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == ST_IDLE)
      else $error("end beat taken while converting");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      done && !snap_ff.ok |-> acc_ff == '0)
      else $error("malformed text gives nonzero time");

endmodule

// ----- rtl/timestamp_text_to_microseconds_top.sv -----
// Channel | Dir | Payload                         | Beat
// req_    | in  | mode, char_code[7:0]            | one text character or end mark
// rsp_    | out | time_us[62:0], valid_res        | one result per end beat
//
// Character beats are taken while the converter is idle; req_ready is low while busy.
// An end beat runs six acc*k + addend passes on the shared multiply-add unit,
// with req_ready low; a malformed text skips them and goes to the hold state.
// The result sits in an output register, and characters of the next text are
// taken while it waits. If it is still full when a new result is ready, the
// converter holds it and req_ready stays low. Reset is synchronous, active high.
module timestamp_text_to_microseconds_top import ttus_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ttus_req_if.sink   req_chan,
   ttus_rsp_if.source rsp_chan
);

   logic              req_take;
   logic              take_char;
   logic              take_end;
   snap_type          snap;
   logic              conv_busy;
   logic              conv_done;
   logic [TIME_W-1:0] conv_time;
   logic              conv_vres;
   logic              out_free;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0] rsp_time_ff;
   logic              rsp_vres_ff;

   // ready tracks converter busy alone, so character beats also wait while it converts
   assign req_chan.ready = !conv_busy;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign take_char      = req_take && !req_chan.mode;
   assign take_end       = req_take && req_chan.mode;

   ttus_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .take_char (take_char),
      .take_end  (take_end),
      .char_code (req_chan.char_code),
      .snap      (snap)
   );

   // output register empty, or emptied this cycle
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   ttus_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .start     (take_end),
      .snap      (snap),
      .out_free  (out_free),
      .busy      (conv_busy),
      .done      (conv_done),
      .time_us   (conv_time),
      .valid_res (conv_vres)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (conv_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (conv_done) begin
         rsp_time_ff <= conv_time;
         rsp_vres_ff <= conv_vres;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.time_us   = rsp_time_ff;
   assign rsp_chan.valid_res = rsp_vres_ff;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import ttus_pkg::*;

   // Beat encodings on the request channel
   localparam logic MODE_CHAR = 1'b0;
   localparam logic MODE_END  = 1'b1;

   localparam int SECONDS_PER_HOUR = 3600;
   localparam int SECONDS_PER_MIN  = 60;
   localparam int MILLI            = 1000;

   localparam int PHASE_BEATS  = 360;   // minimum beats queued per pacing phase
   localparam int HOLD_CYCLES  = 400;   // long rsp_ back-pressure stretch
   localparam int STALL_LIMIT  = 3000;  // cycles without any handshake
   localparam int DRAIN_CYCLES = 20;    // idle cycles after the last phase, before the report

   typedef struct packed {
      logic              mode;
      logic [CHAR_W-1:0] code;
   } text_beat_type;

   typedef struct packed {
      logic [TIME_W-1:0] time_us;
      logic              valid_res;
   } stamp_result_type;

   logic clock;
   logic reset;

   ttus_req_if req_bus ();
   ttus_rsp_if rsp_bus ();

   timestamp_text_to_microseconds_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Beats waiting for the driver, and timestamps waiting on rsp_
   text_beat_type    pending_beats[$];
   stamp_result_type pending_stamps[$];
   logic [CHAR_W-1:0] draft[$];   // text under construction

   int send_idle_pct = 37;
   int recv_idle_pct = 46;
   int phase_id      = 0;
   bit rsp_held      = 0;

   int req_offered   = 0;   // beats put on the bus by the driver
   int req_beats     = 0;   // beats accepted (monitor)
   int queued_beats  = 0;
   int text_count    = 0;
   int valid_seen    = 0;
   int invalid_seen  = 0;
   int mismatches    = 0;
   int quiet_cycles  = 0;

   // Shadow parser: mirrors what the block should have absorbed so far
   logic [PART_W-1:0] scan_part [3];
   logic [1:0]        scan_idx;
   bit                scan_digit;
   bit                scan_in_frac;
   logic [FRAC_W-1:0] scan_frac;
   logic [FDIG_W-1:0] scan_fdig;
   bit                scan_content;
   bit                scan_trail;
   bit                scan_bad;

   function automatic void clear_scan();
      scan_part[0] = '0;
      scan_part[1] = '0;
      scan_part[2] = '0;
      scan_idx     = '0;
      scan_digit   = 0;
      scan_in_frac = 0;
      scan_frac    = '0;
      scan_fdig    = '0;
      scan_content = 0;
      scan_trail   = 0;
      scan_bad     = 0;
   endfunction

   function automatic void scan_char(input logic [CHAR_W-1:0] c);
      logic [63:0] grown;
      logic [3:0]  digit;
      bit          blank;
      blank = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
      digit = 4'(c - CHAR_ZERO);
      if (scan_bad) return;
      if (blank) begin
         // whitespace after content only matters if more content follows
         if (scan_content) scan_trail = 1;
         return;
      end
      if (scan_trail) begin
         scan_bad = 1;
         return;
      end
      scan_content = 1;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         if (scan_in_frac) begin
            // digits past the third are dropped
            if (scan_fdig < FDIG_MAX) begin
               scan_frac = FRAC_W'(scan_frac * 10 + digit);
               scan_fdig = scan_fdig + 1'b1;
            end
         end else begin
            grown = 64'(scan_part[scan_idx]) * 64'd10 + 64'(digit);
            if (grown > 64'(PART_MAX)) begin
               scan_bad = 1;
            end else begin
               scan_part[scan_idx] = grown[PART_W-1:0];
               scan_digit = 1;
            end
         end
      end else if (c == CHAR_COLON) begin
         if (scan_in_frac || !scan_digit || scan_idx >= PART_COUNT_LAST) begin
            scan_bad = 1;
         end else begin
            scan_idx   = scan_idx + 1'b1;
            scan_digit = 0;
         end
      end else if (c == CHAR_DOT || c == CHAR_COMMA) begin
         if (scan_in_frac || !scan_digit) scan_bad = 1;
         else scan_in_frac = 1;
      end else begin
         scan_bad = 1;
      end
   endfunction

   // End beat: fold the parts into microseconds, then start a fresh text
   function automatic stamp_result_type close_text();
      stamp_result_type r;
      logic [63:0]      hh, mm, ss, msec, total;
      bit               ok;
      ok = !scan_bad && scan_content && scan_idx >= 1 && scan_digit;
      if (scan_idx == PART_COUNT_LAST) begin
         hh = 64'(scan_part[0]);
         mm = 64'(scan_part[1]);
         ss = 64'(scan_part[2]);
      end else begin
         hh = '0;
         mm = 64'(scan_part[0]);
         ss = 64'(scan_part[1]);
      end
      case (scan_fdig)
         2'd1:    msec = 64'(scan_frac) * 64'd100;
         2'd2:    msec = 64'(scan_frac) * 64'd10;
         default: msec = 64'(scan_frac);
      endcase
      total = ((hh * SECONDS_PER_HOUR + mm * SECONDS_PER_MIN + ss) * MILLI + msec) * MILLI;
      r.time_us   = ok ? total[TIME_W-1:0] : '0;
      r.valid_res = ok;
      clear_scan();
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
   endtask

   // ---------------------------------------------------------------
   // Text building
   // ---------------------------------------------------------------
   task automatic add_byte(input logic [CHAR_W-1:0] c);
      draft = {draft, c};
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   // up to 'most' whitespace bytes: space or one of TAB..CR
   task automatic add_blanks(input int most);
      int n, k;
      n = $urandom_range(most);
      repeat (n) begin
         k = $urandom_range(5);
         add_byte(k == 0 ? CHAR_SPACE : CHAR_W'(CHAR_TAB + k - 1));
      end
   endtask

   // one integer part, mostly clock-like, sometimes near or past the limit
   task automatic add_part();
      longint unsigned v;
      int pick;
      pick = $urandom_range(9);
      case (pick)
         0, 1, 2, 3, 4, 5: v = $urandom_range(59);
         6:                v = $urandom_range(999999);
         7:                v = longint'(PART_MAX) - 8 + $urandom_range(16);
         8:                v = $urandom;
         default:          v = $urandom_range(9);
      endcase
      if (pick == 9 || $urandom_range(3) == 0)
         repeat ($urandom_range(1, 3)) add_byte(CHAR_ZERO);
      add_str($sformatf("%0d", v));
   endtask

   task automatic build_timestamp();
      int parts;
      add_blanks(2);
      parts = $urandom_range(2, 3);
      for (int i = 0; i < parts; i++) begin
         if (i != 0) add_byte(CHAR_COLON);
         add_part();
      end
      if ($urandom_range(1)) begin
         add_byte($urandom_range(1) ? CHAR_DOT : CHAR_COMMA);
         repeat ($urandom_range(5)) add_byte(CHAR_W'(CHAR_ZERO + $urandom_range(9)));
      end
      add_blanks(2);
   endtask

   // queue the draft as character beats plus an end beat with a junk byte
   task automatic send_draft();
      text_beat_type b;
      foreach (draft[i]) begin
         b.mode = MODE_CHAR;
         b.code = draft[i];
         pending_beats = {pending_beats, b};
      end
      b.mode = MODE_END;
      b.code = CHAR_W'($urandom_range(255));
      pending_beats = {pending_beats, b};
      queued_beats += draft.size() + 1;
      text_count++;
      draft.delete();
   endtask

   task automatic send_text(input string s);
      add_str(s);
      send_draft();
   endtask

   // ---------------------------------------------------------------
   // Clock and reset
   // ---------------------------------------------------------------
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset             = 1;
      req_bus.valid     = 0;
      req_bus.mode      = MODE_CHAR;
      req_bus.char_code = '0;
      rsp_bus.ready     = 0;
      clear_scan();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
   end

   // ---------------------------------------------------------------
   // Request driver: holds a beat until the monitor has seen it taken
   // ---------------------------------------------------------------
   always @(negedge clock) begin : req_driver
      text_beat_type nxt;
      if (reset) begin
         req_bus.valid <= 0;
      end else if (!(req_bus.valid && req_beats != req_offered)) begin
         if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_beats.pop_front();
            req_bus.valid     <= 1;
            req_bus.mode      <= nxt.mode;
            req_bus.char_code <= nxt.code;
            req_offered++;
         end else begin
            req_bus.valid <= 0;
         end
      end
   end

   // Result side: random idling, plus the long hold-off below
   always @(negedge clock) begin
      rsp_bus.ready <= !rsp_held && ($urandom_range(99) >= recv_idle_pct);
   end

   // Long back-pressure at the start of the last phase; characters keep
   // flowing until the second end beat finds the output register full
   initial begin
      wait (phase_id == 2);
      @(posedge clock);
      rsp_held = 1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_held = 0;
   end

   // ---------------------------------------------------------------
   // Monitor: predicts on every request beat, checks every result beat
   // ---------------------------------------------------------------
   always @(posedge clock) begin : monitor
      stamp_result_type want;
      bit               moved;
      if (!reset) begin
         moved = 0;
         if (req_bus.valid && req_bus.ready) begin
            moved = 1;
            req_beats++;
            if (req_bus.mode == MODE_END) pending_stamps = {pending_stamps, close_text()};
            else scan_char(req_bus.char_code);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1;
            if (rsp_bus.valid_res) valid_seen++;
            else invalid_seen++;
            if (pending_stamps.size() == 0) begin
               report_mismatch("unexpected result time_us", 64'(rsp_bus.time_us), 0);
            end else begin
               want = pending_stamps.pop_front();
               if (rsp_bus.time_us !== want.time_us)
                  report_mismatch("time_us", 64'(rsp_bus.time_us), 64'(want.time_us));
               if (rsp_bus.valid_res !== want.valid_res)
                  report_mismatch("valid_res", 64'(rsp_bus.valid_res), 64'(want.valid_res));
            end
         end
         // watchdog on handshake-free stretches
         if (moved) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus: three pacing phases of random texts, the first led by directed texts
   // ---------------------------------------------------------------
   initial begin : stimulus
      int pick, pos;
      logic [CHAR_W-1:0] junk;
      @(posedge clock);
      while (reset) @(posedge clock);

      for (int p = 0; p < 3; p++) begin
         phase_id      = p;
         send_idle_pct = (p == 0) ? 37 : (p == 1) ? 46 : 0;
         recv_idle_pct = (p == 0) ? 46 : (p == 1) ? 37 : 0;
         queued_beats  = 0;

         if (p == 0) begin
            send_text("");                                   // empty text
            add_str(" \t\r\n");                              // whitespace only
            add_byte(8'h0B);
            add_byte(8'h0C);
            send_draft();
            send_text("59");                                 // single part
            send_text("1:2:3:4");                            // too many parts
            send_text(":5");                                 // empty parts
            send_text("1:");
            send_text("1:.5");
            send_text("1: 2");                               // inner whitespace
            add_str("1:2");                                  // foreign bytes
            add_byte(8'hFF);
            send_draft();
            add_byte(8'h00);
            add_str("0:0");
            send_draft();
            send_text("1.5:2");                              // fraction then colon
            send_text("1:2.3.4");                            // second mark
            send_text("2147483648:0");                       // part overflow
            send_text("2147483647:2147483647:2147483647.999");
            send_text("1:2.");                               // empty fraction
            send_text(" \r\n01:02:03,12345 \n");             // padding, truncation
            send_text("0:0");
            send_text("1:2.5");
            send_text("1:2,05");
            send_text("12:x:::9");                           // junk after error
         end

         while (queued_beats < PHASE_BEATS) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               build_timestamp();
            end else if (pick < 90) begin
               // well-formed text with one defect
               build_timestamp();
               case ($urandom_range(2))
                  0: begin
                     pos  = $urandom_range(draft.size());
                     junk = $urandom_range(1) ? CHAR_W'($urandom_range(255)) :
                            ($urandom_range(1) ? CHAR_COLON : CHAR_DOT);
                     draft.insert(pos, junk);
                  end
                  1: if (draft.size() > 0) draft.delete($urandom_range(draft.size() - 1));
                  default: begin
                     add_byte(CHAR_COLON);
                     add_part();
                  end
               endcase
            end else begin
               repeat ($urandom_range(1, 8)) add_byte(CHAR_W'($urandom_range(255)));
            end
            send_draft();
         end

         while (pending_beats.size() != 0 || req_beats != req_offered ||
                pending_stamps.size() != 0)
            @(posedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d texts in %0d beats across three pacing phases with a long result stall.",
               text_count, req_beats);
      $display("Results: %0d valid timestamps, %0d rejected, %0d mismatches.",
               valid_seen, invalid_seen, mismatches);
      if (mismatches == 0 && pending_stamps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
